[rtl/lfr_pkg.sv]
// Shared types and constants for the long FIR reverb convolver.
// No dependencies; used by the top level long_fir_reverb_convolver.
package lfr_pkg;

    // Fixed field widths of the item and register interface.
    localparam int TAP_INDEX_W = 10;
    localparam int TAP_COUNT_W = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = TAP_COUNT_W;

    // Operation codes carried by an input word.
    typedef enum logic {
        OP_LOAD_TAP = 1'b0,
        OP_SAMPLE   = 1'b1
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 1'b1;

    // Mode register values.
    localparam logic MODE_BYPASS = 1'b0;
    localparam logic MODE_REVERB = 1'b1;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 11'd1024;

endpackage

[rtl/lfr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instantiated by long_fir_reverb_convolver.
module lfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/long_fir_reverb_convolver.sv]
// Top level of the long FIR reverb convolver: control, MAC pipeline and output register.
// Depends on lfr_pkg (codes and widths) and lfr_ram (tap and sample history storage).
//
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one word per item. A word with
// operation OP_LOAD_TAP writes one impulse response tap into tap memory and yields no
// result; a word with operation OP_SAMPLE pushes one audio sample into the history ring
// and yields exactly one output word (o_out_valid / i_out_ready).
// In bypass mode an accepted sample goes straight to the final state and comes back
// unchanged through the output register; then the next word can be taken. In reverb
// mode one shared multiply-accumulate walks the L taps in use, one tap a cycle, reading
// the tap memory and the history memory in parallel; once the MAC pipeline drains, the
// final state scales and saturates the sum into the output register, and then the next
// word can be taken. Load words are taken one per cycle while no sample is in flight.
// The block works on one sample at a time; o_in_ready is high whenever no sample is in
// flight, also while a finished word waits in the output register. If the receiver
// stalls, the finished result holds in its final state until the output register frees
// up; o_out_valid and the payload stay put until taken. Reset (synchronous, active low)
// clears mode to bypass, the tap count to 1024, the history write pointer and the
// history fill count. The history reads as zero for entries not yet written since
// reset, so no clearing pass is needed. Taps are undefined until loaded. Configuration
// is written through i_cfg_we only while idle, a check that is left to the user.
module long_fir_reverb_convolver #(
    parameter int TAPS        = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [lfr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [lfr_pkg::TAP_INDEX_W-1:0]   i_tap_index,
    input  logic signed [SAMPLE_BITS-1:0]     i_value,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_out_sample,
    output logic                              o_clipped
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(TAPS);
    localparam int CW    = $clog2(TAPS + 1);
    localparam int TI_W  = lfr_pkg::TAP_INDEX_W;
    localparam int TC_W  = lfr_pkg::TAP_COUNT_W;
    // The exact sum needs 2*SB + log2(TAPS) bits; beyond 64 bits it wraps modulo 2^64.
    localparam int ACC_FULL = 2 * SB + AW + 1;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int SH_W     = ACC_W - SB + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    localparam logic signed [SB-1:0] MAX_VAL = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] MIN_VAL = {1'b1, {(SB-1){1'b0}}};

    // Configuration registers.
    logic                   r_mode;
    logic [TC_W-1:0]        r_tap_count;

    // Control state.
    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [AW-1:0]          r_wp;
    logic [CW-1:0]          r_fill;
    logic [CW-1:0]          r_k;
    logic [CW-1:0]          r_len;
    logic [AW-1:0]          r_pos;
    logic                   r_s1_v;
    logic                   r_s1_ok;
    logic                   r_s2_v;
    logic signed [2*SB-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // Output register.
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic signed [SB-1:0]   r_out_sample;
    logic                   r_clipped;

    logic                   w_in_acc;
    logic                   w_load;
    logic                   w_sample;
    logic                   w_tap_ok;
    logic [AW+TI_W-1:0]     w_tap_ext;
    logic [CW+TC_W-1:0]     w_tc_ext;
    logic [CW-1:0]          w_len;
    logic                   w_issue;
    logic                   w_mac_done;
    logic                   w_out_free;
    logic [SB-1:0]          w_coef_rd;
    logic [SB-1:0]          w_hist_rd;
    logic signed [SB-1:0]   w_hist_op;
    logic signed [2*SB-1:0] w_prod;
    logic signed [SH_W-1:0] w_sh;
    logic [SH_W-SB:0]       w_top;
    logic                   w_clip;
    logic signed [SB-1:0]   w_sat;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load     = w_in_acc && (i_operation == lfr_pkg::OP_LOAD_TAP);
    assign w_sample   = w_in_acc && (i_operation == lfr_pkg::OP_SAMPLE);

    // Loads beyond the tap memory are dropped.
    assign w_tap_ok  = 32'(i_tap_index) < 32'(TAPS);
    assign w_tap_ext = {{AW{1'b0}}, i_tap_index};

    // Taps in use: a count of zero acts as one, a count above TAPS as TAPS.
    assign w_tc_ext = {{CW{1'b0}}, r_tap_count};
    always_comb begin
        if (r_tap_count == '0) begin
            w_len = CW'(1);
        end else if (32'(r_tap_count) >= 32'(TAPS)) begin
            w_len = CW'(TAPS);
        end else begin
            w_len = w_tc_ext[CW-1:0];
        end
    end

    lfr_ram #(
        .WIDTH (SB),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_load && w_tap_ok),
        .i_waddr (w_tap_ext[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_coef_rd)
    );

    // The new sample is written at acceptance, before the MAC reads it, so the
    // registered read always returns the fresh value.
    lfr_ram #(
        .WIDTH (SB),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_sample),
        .i_waddr (r_wp),
        .i_wdata (i_value),
        .i_raddr (r_pos),
        .o_rdata (w_hist_rd)
    );

    // History entries older than the fill count were never written since reset
    // and count as zero.
    assign w_hist_op = r_s1_ok ? $signed(w_hist_rd) : '0;
    assign w_prod    = $signed(w_coef_rd) * w_hist_op;

    assign w_issue    = (r_state == ST_MAC) && (r_k < r_len);
    assign w_mac_done = (r_state == ST_MAC) && !w_issue && !r_s1_v && !r_s2_v;

    // Final scaling: floor shift by SB-1, then saturate to SB bits.
    assign w_sh   = r_acc[ACC_W-1:SB-1];
    assign w_top  = w_sh[SH_W-1:SB-1];
    assign w_clip = !((&w_top) || !(|w_top));
    assign w_sat  = w_clip ? (w_sh[SH_W-1] ? MIN_VAL : MAX_VAL) : w_sh[SB-1:0];

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_sample) begin
                    n_state = (r_mode == lfr_pkg::MODE_REVERB) ? ST_MAC : ST_FINAL;
                end
            end
            ST_MAC: begin
                if (w_mac_done) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == ST_FINAL) && w_out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= lfr_pkg::MODE_BYPASS;
            r_tap_count <= lfr_pkg::TAP_COUNT_RESET;
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lfr_pkg::REG_MODE:      r_mode      <= i_cfg_wdata[0];
                    lfr_pkg::REG_TAP_COUNT: r_tap_count <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_sample) begin
                r_wp <= (r_wp == AW'(TAPS - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != CW'(TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_k <= '0;
            end else if (w_issue) begin
                r_k <= r_k + 1'b1;
            end
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_len <= w_len;
            r_pos <= r_wp;
            // Bypass parks the sample pre-scaled so the final stage returns it as is.
            // Reverb starts the sum from zero.
            r_acc <= (r_mode == lfr_pkg::MODE_REVERB) ? '0
                                                       : (ACC_W'(i_value) <<< (SB - 1));
        end else begin
            if (w_issue) begin
                r_pos <= (r_pos == '0) ? AW'(TAPS - 1) : r_pos - 1'b1;
            end
            if (r_s2_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_s1_ok <= r_k < r_fill;
        r_prod  <= w_prod;
        if ((r_state == ST_FINAL) && w_out_free) begin
            r_out_sample <= w_sat;
            r_clipped    <= w_clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_clipped    = r_clipped;

    // The tap walk never runs past the number of taps in use.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k <= r_len))
        else $error("tap counter ran past the tap count");

    // The fill count saturates at the history depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TAPS))
        else $error("history fill count exceeds depth");

    // MAC pipeline stages carry work only while a sample is being filtered.
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MAC) |-> (!r_s1_v && !r_s2_v))
        else $error("MAC pipeline busy outside the MAC phase");

    // A bypassed sample goes straight to the final stage.
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sample && (r_mode == lfr_pkg::MODE_BYPASS)) |=> (r_state == ST_FINAL))
        else $error("bypassed sample did not go to the final stage");

    // A new result is loaded only from the final stage.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_out_ready) && (r_state != ST_FINAL) |=> !r_out_valid)
        else $error("output word appeared without a finished sample");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for long_fir_reverb_convolver: directed and random tap loads,
// samples and register settings, checked against an in-bench convolution predictor.
// Depends on lfr_pkg and the long_fir_reverb_convolver RTL; needs nothing else.
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_TAPS    = 1024;
    localparam int TOTAL_WORDS = 580;
    // Long enough for a sample at the widest span used here; this also covers any
    // late stray word.
    localparam int DRAIN_CYCLES = 1100;
    // Loads complete at acceptance, so this is ample before a register write.
    localparam int SETTLE_CYCLES = 32;

    // One result word as the output channel delivers it.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
    } t_out_word;

    // The scoreboard keeps its own copy of the tap table, the history ring and the
    // registers. Every accepted sample word is convolved here at once, and the
    // result is queued until the block hands back the matching output word.
    class reverb_scoreboard;
        logic signed [15:0] taps [NUM_TAPS];
        bit                 tap_loaded [NUM_TAPS];
        logic signed [15:0] history [NUM_TAPS];
        int                 wr_ptr;
        logic               mode_r;
        logic [10:0]        count_r;
        t_out_word          expected_outputs [$];
        int                 errors;
        int                 checked;
        int                 clipped_seen;

        function new();
            for (int i = 0; i < NUM_TAPS; i++) begin
                taps[i]       = '0;
                tap_loaded[i] = 1'b0;
                history[i]    = '0;
            end
            wr_ptr       = 0;
            mode_r       = lfr_pkg::MODE_BYPASS;
            count_r      = lfr_pkg::TAP_COUNT_RESET;
            errors       = 0;
            checked      = 0;
            clipped_seen = 0;
        endfunction

        function void set_config(logic m, logic [10:0] cnt);
            mode_r  = m;
            count_r = cnt;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        // Direct-form FIR over the history ring, newest sample first.
        function t_out_word convolve_sample();
            t_out_word res;
            longint    acc;
            longint    y;
            int        span;
            int        pos;
            acc  = 0;
            span = (count_r == 0) ? 1 : ((count_r > NUM_TAPS) ? NUM_TAPS : int'(count_r));
            pos  = wr_ptr;
            for (int k = 0; k < span; k++) begin
                acc += longint'(taps[k]) * longint'(history[pos]);
                pos = (pos == 0) ? NUM_TAPS - 1 : pos - 1;
            end
            // Arithmetic shift rounds toward minus infinity, as Q1.15 truncation should.
            y = acc >>> 15;
            res.clipped = 1'b0;
            if (y > 32767) begin
                y           = 32767;
                res.clipped = 1'b1;
            end else if (y < -32768) begin
                y           = -32768;
                res.clipped = 1'b1;
            end
            res.sample = y[15:0];
            return res;
        endfunction

        function void note_word(lfr_pkg::t_op op, logic [9:0] idx, logic signed [15:0] val);
            t_out_word res;
            if (op == lfr_pkg::OP_LOAD_TAP) begin
                taps[idx]       = val;
                tap_loaded[idx] = 1'b1;
            end else begin
                history[wr_ptr] = val;
                if (mode_r == lfr_pkg::MODE_BYPASS) begin
                    res.sample  = val;
                    res.clipped = 1'b0;
                end else begin
                    res = convolve_sample();
                end
                wr_ptr = (wr_ptr + 1) % NUM_TAPS;
                expected_outputs.push_back(res);
            end
        endfunction

        function void check_result(logic signed [15:0] sample, logic clipped);
            t_out_word exp_w;
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected output word sample=%0d clipped=%0b",
                         $time, sample, clipped);
                errors++;
                return;
            end
            exp_w = expected_outputs.pop_front();
            checked++;
            if (clipped) clipped_seen++;
            if (sample !== exp_w.sample) begin
                $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                         $time, exp_w.sample, sample);
                errors++;
            end
            if (clipped !== exp_w.clipped) begin
                $display("%0t: clipped mismatch, expected %0b, actual %0b",
                         $time, exp_w.clipped, clipped);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [lfr_pkg::CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [lfr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic                              i_operation = lfr_pkg::OP_LOAD_TAP;
    logic [lfr_pkg::TAP_INDEX_W-1:0]   i_tap_index = '0;
    logic signed [15:0]                i_value     = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [15:0]                o_out_sample;
    logic                              o_clipped;

    reverb_scoreboard sb = new();

    int send_idle_pct = 36;
    int recv_idle_pct = 55;
    int random_words  = 0;
    int words_sent    = 0;
    int rounds_run    = 0;

    long_fir_reverb_convolver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_tap_index  (i_tap_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample),
        .o_clipped    (o_clipped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side. The check uses the values that stood at the edge, and the new
    // ready decision for the next edge is scheduled afterwards.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_sample, o_clipped);
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Mix of full-scale values, zero, unit steps, small values and fully random words,
    // so that both clipping directions and the rounding of small negatives appear.
    function automatic logic signed [15:0] pick_value();
        int t;
        t = $urandom_range(0, 1023) - 512;
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return $urandom_range(0, 1) ? 16'sh0001 : 16'shFFFF;
            4, 5:    return t[15:0];
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one word. Valid stays high after acceptance; the next call either keeps
    // it high with new payload or lowers it for an idle gap, in the same time step,
    // so the stale word is never taken twice.
    task automatic send_word(lfr_pkg::t_op op, logic [9:0] idx, logic signed [15:0] val);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_tap_index <= idx;
        i_value     <= val;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, idx, val);
        words_sent++;
    endtask

    // Drops valid and waits until every expected word is back and loads have settled.
    task automatic wait_idle(int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Both registers are written on consecutive cycles with the enable held high.
    task automatic write_config(logic m, logic [10:0] cnt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lfr_pkg::REG_MODE;
        i_cfg_wdata <= {{(lfr_pkg::CFG_DATA_W - 1){1'b0}}, m};
        @(posedge i_clk);
        i_cfg_index <= lfr_pkg::REG_TAP_COUNT;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(m, cnt);
    endtask

    // Loads every tap below the span that has never been written, so that a
    // reverb sample never reads an undefined coefficient.
    task automatic load_missing(int span);
        for (int i = 0; i < span; i++)
            if (!sb.tap_loaded[i])
                send_word(lfr_pkg::OP_LOAD_TAP, 10'(i), pick_value());
    endtask

    // Random body of one round: mostly samples, with tap rewrites inside the active
    // span and a few loads anywhere in the table.
    task automatic run_body(int words, int span);
        int r;
        for (int n = 0; n < words; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_word(lfr_pkg::OP_LOAD_TAP, 10'($urandom_range(0, span - 1)),
                          pick_value());
            else if (r < 15)
                send_word(lfr_pkg::OP_LOAD_TAP, 10'($urandom_range(0, NUM_TAPS - 1)),
                          pick_value());
            else
                send_word(lfr_pkg::OP_SAMPLE, 10'($urandom), pick_value());
            random_words++;
        end
    endtask

    initial begin
        int          words;
        int          span;
        logic        m;
        logic [10:0] cnt;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Bypass right after reset checks the reset mode and the
        // full-scale edges of the sample field.
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh7FFF);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh8000);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh0000);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh0001);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'shFFFF);
        // Taps for the clipping cases, plus the top tap index.
        send_word(lfr_pkg::OP_LOAD_TAP, 10'd0, 16'sh8000);
        send_word(lfr_pkg::OP_LOAD_TAP, 10'd1, 16'sh8000);
        send_word(lfr_pkg::OP_LOAD_TAP, 10'd2, 16'sh7FFF);
        send_word(lfr_pkg::OP_LOAD_TAP, 10'd3, 16'sh0001);
        send_word(lfr_pkg::OP_LOAD_TAP, 10'h3FF, 16'sd12345);

        // A tap count of zero acts as one tap; minus one times minus one overflows.
        wait_idle(SETTLE_CYCLES);
        write_config(lfr_pkg::MODE_REVERB, 11'd0);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh8000);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh7FFF);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'shFFFF);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh0001);

        // Two full-scale taps drive the sum past both rails.
        wait_idle(SETTLE_CYCLES);
        write_config(lfr_pkg::MODE_REVERB, 11'd2);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh8000);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh8000);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh7FFF);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh7FFF);

        // Small negative sums check that the shift rounds toward minus infinity.
        wait_idle(SETTLE_CYCLES);
        write_config(lfr_pkg::MODE_REVERB, 11'd4);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'shFFFF);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh0000);
        send_word(lfr_pkg::OP_SAMPLE, '0, 16'sh0005);

        // Random rounds. Each one writes both registers while idle, fills any taps the
        // new span needs, then runs a random body. A few rounds hit chosen tap counts;
        // spans stay short so the tap loads do not crowd out the samples.
        while (words_sent < TOTAL_WORDS) begin
            if (words_sent < TOTAL_WORDS / 3) begin
                send_idle_pct = 36;
                recv_idle_pct = 55;
            end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            words = $urandom_range(16, 32);
            m     = ($urandom_range(0, 3) != 0) ? lfr_pkg::MODE_REVERB : lfr_pkg::MODE_BYPASS;
            cnt   = 11'($urandom_range(1, 48));
            case (rounds_run)
                2: begin
                    // The widest span of the run.
                    m     = lfr_pkg::MODE_REVERB;
                    cnt   = 11'd96;
                    words = 12;
                end
                8: begin
                    m   = lfr_pkg::MODE_REVERB;
                    cnt = 11'd0;
                end
                11: begin
                    m   = lfr_pkg::MODE_REVERB;
                    cnt = 11'd1;
                end
                default: begin
                    // The count is unused in bypass, so any value of the field may go in.
                    if (m == lfr_pkg::MODE_BYPASS)
                        cnt = 11'($urandom_range(0, 2047));
                end
            endcase
            span = (cnt == 0) ? 1 : ((cnt > NUM_TAPS) ? NUM_TAPS : int'(cnt));
            wait_idle(SETTLE_CYCLES);
            write_config(m, cnt);
            if (m == lfr_pkg::MODE_REVERB)
                load_missing(span);
            run_body(words, span);
            rounds_run++;
        end

        wait_idle(DRAIN_CYCLES);
        $display("Sent %0d words, %0d of them random, over %0d register settings.",
                 words_sent, random_words, rounds_run);
        $display("Checked %0d output words, %0d of them saturated.",
                 sb.checked, sb.clipped_seen);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: the slowest legal run needs only a small fraction of this.
    initial begin
        #5_000_000;
        $display("Timeout with %0d output words still expected.", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
